>>> rtl/tree_bitmap_ipv6_lookup_macros.svh
// Assertion macros for the tree bitmap lookup block.
`ifndef TREE_BITMAP_IPV6_LOOKUP_MACROS_SVH
`define TREE_BITMAP_IPV6_LOOKUP_MACROS_SVH
`ifndef SYNTH
`define TBL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tree bitmap lookup check failed");
`define TBL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tree bitmap lookup check failed");
`else
`define TBL_ASSERT_IMPL(label, ante, cons)
`define TBL_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/tbl_pkg.sv
// Shared constants, types and the prefix match function of the lookup block.
package tbl_pkg;
    localparam int NODES  = 4096;
    localparam int NODE_W = 12;
    localparam int LEVELS = 33;
    localparam int NIBS   = 32;
    localparam int LVL_W  = 6;

    localparam logic [1:0] FN_BITS = 2'd0;
    localparam logic [1:0] FN_LINK = 2'd1;
    localparam logic [1:0] FN_HOP  = 2'd2;
    localparam logic [1:0] FN_LOOK = 2'd3;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

    function automatic logic [3:0] match_pos(input logic [15:0] ib, input logic [3:0] nib,
                                             input logic last);
        logic [3:0] p8;
        logic [3:0] p4;
        logic [3:0] p2;
        p8 = 4'd8 + {1'b0, nib[3:1]};
        p4 = 4'd4 + {2'b0, nib[3:2]};
        p2 = 4'd2 + {3'b0, nib[3]};
        if (!last && ib[p8]) begin
            return p8;
        end else if (!last && ib[p4]) begin
            return p4;
        end else if (!last && ib[p2]) begin
            return p2;
        end else if (ib[1]) begin
            return 4'd1;
        end
        return 4'd0;
    endfunction
endpackage

>>> rtl/tbl_nib_cell.sv
// One address nibble cell of the shift chain that feeds the walk.
module tbl_nib_cell (
    input  logic              i_clk,
    input  tbl_pkg::t_cell_ctl i_ctl,
    input  logic [3:0]        i_load_nib,
    input  logic [3:0]        i_next_nib,
    output logic [3:0]        o_nib
);
    logic [3:0] r_nib;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_nib <= i_load_nib;
        end else if (i_ctl.shift) begin
            r_nib <= i_next_nib;
        end
    end

    assign o_nib = r_nib;
endmodule

>>> rtl/tree_bitmap_ipv6_lookup.sv
// Top level: node stores, nibble cell chain and the lookup walk.
// The slave channel takes one request per item: tuser carries the function
// code, tdata the node, slot, bitmaps, link, hop and the IPv6 address.
// Writes (bitmaps, child link, next hop) take effect on acceptance and return a
// result of all zeros. A lookup loads the 32 address nibbles into a chain of
// cells that shifts one nibble toward the walker for each level, and reads
// one trie node per cycle from the bitmap and link memories, whose
// registered read data addresses the next level directly.
// A lookup reads between 1 and 33 nodes before its result is set.
// One request is in the block at a time; a new one is taken when the block
// is idle and the output register is empty or being drained, so the next
// request after a lookup is accepted only after its walk has ended.
// The result waits in the output register while the master side stalls.
// After reset the block sweeps the 4096 bitmap entries to zero, one per
// cycle, and takes no request during the sweep.
`include "tree_bitmap_ipv6_lookup_macros.svh"
module tree_bitmap_ipv6_lookup (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // node, slot, internal_bits, external_bits, link, hop_in, addr_high, addr_low
    input  logic [199:0] s_axis_tdata,
    // func
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // found, hop_out, nodes_visited
    output logic [15:0]  m_axis_tdata
);
    localparam logic [1:0] ST_CLR  = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]  r_state;
    logic [tbl_pkg::NODE_W-1:0] r_clr_cnt;
    logic [tbl_pkg::NODE_W-1:0] r_cur;
    logic [tbl_pkg::LVL_W-1:0]  r_level;
    logic [tbl_pkg::LVL_W-1:0]  r_vis;
    logic        r_found;
    logic [7:0]  r_hop;
    logic        r_hop_pend;
    logic        r_ovalid;
    logic        r_ofound;
    logic [7:0]  r_ohop;
    logic [tbl_pkg::LVL_W-1:0]  r_ovis;

    logic [15:0] int_mem [tbl_pkg::NODES];
    logic [15:0] ext_mem [tbl_pkg::NODES];
    logic [tbl_pkg::NODE_W-1:0] link_mem [tbl_pkg::NODES*16];
    logic [7:0]  hop_mem [tbl_pkg::NODES*16];
    logic [15:0] r_ib;
    logic [15:0] r_eb;
    logic [tbl_pkg::NODE_W-1:0] r_link;
    logic [7:0]  r_hopq;

    logic [1:0]  func;
    logic [11:0] node;
    logic [3:0]  slot;
    logic [127:0] addr;
    logic        acc;
    logic        out_free;
    logic        out_set;
    logic        acc_look;
    logic        last;
    logic [3:0]  nib;
    logic [3:0]  pos;
    logic        cont;
    logic        issue;
    logic [tbl_pkg::NODE_W-1:0] rd_node;
    logic [3:0]  rd_nib;
    logic        bm_we;
    logic [tbl_pkg::NODE_W-1:0] bm_waddr;
    logic [15:0] ib_wd;
    logic [15:0] eb_wd;
    logic        node_ok;
    logic [7:0]  hop_final;
    tbl_pkg::t_cell_ctl cell_ctl;
    logic [3:0]  cell_nib [tbl_pkg::NIBS];

    assign func     = s_axis_tuser;
    assign node     = s_axis_tdata[11:0];
    assign slot     = s_axis_tdata[15:12];
    assign addr     = {s_axis_tdata[131:68], s_axis_tdata[195:132]};
    assign out_free = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && out_free;
    assign acc      = s_axis_tvalid && s_axis_tready;
    assign acc_look = acc && (func == tbl_pkg::FN_LOOK);
    assign out_set  = (acc && !acc_look) || ((r_state == ST_FIN) && out_free);
    assign node_ok  = {1'b0, node} < 13'(tbl_pkg::NODES);

    assign nib  = cell_nib[0];
    assign last = r_level == tbl_pkg::LVL_W'(tbl_pkg::LEVELS - 1);
    assign pos  = tbl_pkg::match_pos(r_ib, nib, last);
    assign cont = !last && r_eb[nib] && ({1'b0, r_link} < 13'(tbl_pkg::NODES));
    assign issue   = acc_look || ((r_state == ST_WALK) && cont);
    assign rd_node = acc_look ? '0 : r_link;
    assign rd_nib  = acc_look ? addr[127:124] : cell_nib[1];
    assign hop_final = r_hop_pend ? r_hopq : r_hop;

    assign cell_ctl.load  = acc_look;
    assign cell_ctl.shift = (r_state == ST_WALK) && cont;

    for (genvar g = 0; g < tbl_pkg::NIBS; g++) begin : g_cell
        logic [3:0] next_nib;
        if (g == tbl_pkg::NIBS - 1) begin : g_tail
            assign next_nib = 4'd0;
        end else begin : g_mid
            assign next_nib = cell_nib[g+1];
        end
        tbl_nib_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (cell_ctl),
            .i_load_nib (addr[127-4*g -: 4]),
            .i_next_nib (next_nib),
            .o_nib      (cell_nib[g])
        );
    end

    assign bm_we    = (r_state == ST_CLR) || (acc && func == tbl_pkg::FN_BITS && node_ok);
    assign bm_waddr = (r_state == ST_CLR) ? r_clr_cnt : node;
    assign ib_wd    = (r_state == ST_CLR) ? 16'd0 : s_axis_tdata[31:16];
    assign eb_wd    = (r_state == ST_CLR) ? 16'd0 : s_axis_tdata[47:32];

    always_ff @(posedge i_clk) begin
        if (bm_we) begin
            int_mem[bm_waddr] <= ib_wd;
            ext_mem[bm_waddr] <= eb_wd;
        end
        if (issue) begin
            r_ib <= int_mem[rd_node];
            r_eb <= ext_mem[rd_node];
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && func == tbl_pkg::FN_LINK && node_ok) begin
            link_mem[{node, slot}] <= s_axis_tdata[59:48];
        end
        if (issue) begin
            r_link <= link_mem[{rd_node, rd_nib}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && func == tbl_pkg::FN_HOP && node_ok) begin
            hop_mem[{node, slot}] <= s_axis_tdata[67:60];
        end
        if (r_state == ST_WALK && pos != 4'd0) begin
            r_hopq <= hop_mem[{r_cur, pos}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLR;
            r_clr_cnt  <= '0;
            r_hop_pend <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (out_set) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_CLR: begin
                    r_clr_cnt <= r_clr_cnt + 1'b1;
                    if (r_clr_cnt == tbl_pkg::NODE_W'(tbl_pkg::NODES - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (acc_look) begin
                        r_state    <= ST_WALK;
                        r_cur      <= '0;
                        r_level    <= '0;
                        r_found    <= 1'b0;
                        r_hop      <= 8'd0;
                        r_hop_pend <= 1'b0;
                    end else if (acc) begin
                        r_ofound <= 1'b0;
                        r_ohop   <= 8'd0;
                        r_ovis   <= '0;
                    end
                end
                ST_WALK: begin
                    if (r_hop_pend) begin
                        r_hop <= r_hopq;
                    end
                    r_hop_pend <= pos != 4'd0;
                    if (pos != 4'd0) begin
                        r_found <= 1'b1;
                    end
                    if (cont) begin
                        r_cur   <= r_link;
                        r_level <= r_level + 1'b1;
                    end else begin
                        r_vis   <= r_level + 1'b1;
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    r_hop      <= hop_final;
                    r_hop_pend <= 1'b0;
                    if (out_free) begin
                        r_ofound <= r_found;
                        r_ohop   <= hop_final;
                        r_ovis   <= r_vis;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_ovis, r_ohop, r_ofound};

    `TBL_ASSERT_IMPL(a_no_req_in_clear, r_state == ST_CLR, !s_axis_tready)
    `TBL_ASSERT_IMPL(a_level_range, r_state == ST_WALK, r_level <= tbl_pkg::LVL_W'(tbl_pkg::LEVELS - 1))
    `TBL_ASSERT_NEXT(a_lookup_starts_walk, acc_look, r_state == ST_WALK)
    `TBL_ASSERT_IMPL(a_no_hop_without_match, r_ovalid && !r_ofound, r_ohop == 8'd0)
endmodule
